// File: rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared types and codes for the sorted key table
// Opcodes, status codes, controller states and the cell control bundle.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int DEPTH_DEFAULT    = 64;
  localparam int KEY_BITS_DEFAULT = 32;
  localparam int KEY_W            = 32;
  localparam int OPCODE_W         = 3;
  localparam int STATUS_W         = 3;

  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_SEARCH = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_REWIND = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_READ   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PAST_END  = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPARE,
    S_APPLY
  } skt_state_t;

  typedef struct packed {
    logic compare;
    logic shift_in;
    logic shift_out;
  } skt_cell_ctrl_t;

endpackage

// File: rtl/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table: ordered table of distinct keys
// Row of compare-and-shift cells with a small sequencing controller.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: tuser carries the opcode, tdata the key. Master
//   channel m_*: tuser carries the status, tdata the found flag, read
//   value, entry count and full flag. One result transaction follows each
//   input transaction, in order.
//   Each item passes through accept, a compare cycle in which every
//   cell registers its less-than, equal and cursor-match flags, and an
//   apply cycle in which the cells shift and the result is registered.
//   No new item is taken until the last has left the apply cycle; the
//   flag registers in the cells serve one item at a time.
//   The result sits in an output register, so the next item is accepted
//   while a result waits. If the receiver stalls, the apply cycle holds
//   until the output register is free, and input is then held off.
//   Reset empties the table and rewinds the cursor; key slots need no
//   clearing as only occupied slots are ever compared or read.
// ----------------------------------------------------------------------------
module sorted_key_table #(
  parameter int DEPTH    = skt_pkg::DEPTH_DEFAULT,
  parameter int KEY_BITS = skt_pkg::KEY_BITS_DEFAULT,
  localparam int CNT_BITS = $clog2(DEPTH + 1),
  localparam int OUT_BITS = 2 + skt_pkg::KEY_W + CNT_BITS,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [skt_pkg::KEY_W-1:0]     s_tdata,   // key
  input  logic [skt_pkg::OPCODE_W-1:0]  s_tuser,   // opcode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [OUT_W-1:0]              m_tdata,   // found, read_value, entry_count,
                                                   // table_full, zero pad
  output logic [skt_pkg::STATUS_W-1:0]  m_tuser    // status
);

  skt_pkg::skt_state_t     state, state_next;
  skt_pkg::skt_cell_ctrl_t ctrl;

  logic [skt_pkg::OPCODE_W-1:0] op;
  logic [KEY_BITS-1:0]          k;
  logic [63:0]                  key_wide;
  logic [CNT_BITS-1:0]          count, count_next;
  logic [CNT_BITS-1:0]          cursor, cursor_next;

  logic [KEY_BITS-1:0] cell_key [DEPTH];
  logic [DEPTH-1:0]    lt_vec, eq_vec, sel_vec;
  logic                any_eq, any_sel;
  logic [KEY_BITS-1:0] rd;
  logic [63:0]         rd_wide;

  logic                         out_free, accept;
  logic [skt_pkg::STATUS_W-1:0] status;
  logic                         found;
  logic [skt_pkg::KEY_W-1:0]    value;
  logic                         full;

  assign key_wide = 64'(s_tdata);
  assign accept   = s_tvalid && s_tready;
  assign s_tready = state == skt_pkg::S_IDLE;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= s_tuser;
      k  <= key_wide[KEY_BITS-1:0];
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [KEY_BITS-1:0] prev_key, next_key;
      logic                prev_lt;
      if (gi == 0) begin : g_first
        assign prev_key = cell_key[gi];
        assign prev_lt  = 1'b1;
      end else begin : g_mid
        assign prev_key = cell_key[gi-1];
        assign prev_lt  = lt_vec[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign next_key = cell_key[gi];
      end else begin : g_inner
        assign next_key = cell_key[gi+1];
      end
      skt_cell #(
        .KEY_BITS (KEY_BITS),
        .CNT_BITS (CNT_BITS),
        .INDEX    (gi)
      ) u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .k        (k),
        .count    (count),
        .cursor   (cursor),
        .prev_key (prev_key),
        .prev_lt  (prev_lt),
        .next_key (next_key),
        .key      (cell_key[gi]),
        .lt       (lt_vec[gi]),
        .eq       (eq_vec[gi]),
        .sel      (sel_vec[gi])
      );
    end
  endgenerate

  assign any_eq  = |eq_vec;
  assign any_sel = |sel_vec;

  always_comb begin
    rd = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd = rd | (cell_key[i] & {KEY_BITS{sel_vec[i]}});
    end
  end

  assign rd_wide = 64'(rd);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= skt_pkg::S_IDLE;
      count    <= '0;
      cursor   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      cursor <= cursor_next;
      if (state == skt_pkg::S_APPLY && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == skt_pkg::S_APPLY && out_free) begin
      m_tuser <= status;
      m_tdata <= OUT_W'({full, count_next, value, found});
    end
  end

  always_comb begin
    state_next  = state;
    ctrl        = '0;
    count_next  = count;
    cursor_next = cursor;
    status      = skt_pkg::ST_DONE;
    found       = 1'b0;
    value       = '0;
    case (state)
      skt_pkg::S_IDLE: begin
        if (accept) begin
          state_next = skt_pkg::S_COMPARE;
        end
      end
      skt_pkg::S_COMPARE: begin
        ctrl.compare = 1'b1;
        state_next   = skt_pkg::S_APPLY;
      end
      skt_pkg::S_APPLY: begin
        if (out_free) begin
          state_next = skt_pkg::S_IDLE;
          case (op)
            skt_pkg::OP_CLEAR: begin
              count_next  = '0;
              cursor_next = '0;
            end
            skt_pkg::OP_INSERT: begin
              if (count == CNT_BITS'(DEPTH)) begin
                status = skt_pkg::ST_FULL;
              end else if (any_eq) begin
                status = skt_pkg::ST_DUPLICATE;
              end else begin
                ctrl.shift_in = 1'b1;
                count_next    = count + CNT_BITS'(1);
              end
            end
            skt_pkg::OP_DELETE: begin
              if (any_eq) begin
                ctrl.shift_out = 1'b1;
                count_next     = count - CNT_BITS'(1);
              end else begin
                status = skt_pkg::ST_NOT_FOUND;
              end
            end
            skt_pkg::OP_SEARCH: begin
              found = any_eq;
            end
            skt_pkg::OP_REWIND: begin
              cursor_next = '0;
            end
            skt_pkg::OP_READ: begin
              if (any_sel) begin
                value       = rd_wide[skt_pkg::KEY_W-1:0];
                cursor_next = cursor + CNT_BITS'(1);
              end else begin
                status = skt_pkg::ST_PAST_END;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_next = skt_pkg::S_IDLE;
      end
    endcase
    full = count_next == CNT_BITS'(DEPTH);
  end

endmodule

// File: rtl/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell: one slot of the sorted key table
// Holds a key, compares it with the broadcast key and shifts to or from
// its neighbours on insert and delete.
// ----------------------------------------------------------------------------
module skt_cell #(
  parameter int KEY_BITS = skt_pkg::KEY_BITS_DEFAULT,
  parameter int CNT_BITS = 7,
  parameter int INDEX    = 0
) (
  input  logic                  clk,
  input  skt_pkg::skt_cell_ctrl_t ctrl,
  input  logic [KEY_BITS-1:0]   k,
  input  logic [CNT_BITS-1:0]   count,
  input  logic [CNT_BITS-1:0]   cursor,
  input  logic [KEY_BITS-1:0]   prev_key,
  input  logic                  prev_lt,
  input  logic [KEY_BITS-1:0]   next_key,
  output logic [KEY_BITS-1:0]   key,
  output logic                  lt,
  output logic                  eq,
  output logic                  sel
);

  logic occ;

  assign occ = count > CNT_BITS'(INDEX);

  always_ff @(posedge clk) begin
    if (ctrl.compare) begin
      lt  <= occ && (key < k);
      eq  <= occ && (key == k);
      sel <= occ && (cursor == CNT_BITS'(INDEX));
    end
    if (ctrl.shift_in && !lt) begin
      key <= prev_lt ? k : prev_key;
    end else if (ctrl.shift_out && !lt) begin
      key <= next_key;
    end
  end

endmodule

// File: tb/sv/sorted_key_table_tb.sv
// ----------------------------------------------------------------------------
// sorted_key_table_tb: self-checking bench for the sorted key table
// Drives opcode and key transactions on the slave stream and checks every
// result on the master stream against a behavioural table kept in the
// bench. A directed table covers empty, extreme and refused cases first;
// random clear, insert, delete, search and cursor walks follow, including
// fills to capacity, under four phases of sender and receiver idling.
// ----------------------------------------------------------------------------
module sorted_key_table_tb;

  localparam int KEY_SLOTS      = skt_pkg::DEPTH_DEFAULT;
  localparam int CNT_W          = $clog2(KEY_SLOTS + 1);
  localparam int OUT_BITS       = 2 + skt_pkg::KEY_W + CNT_W;
  localparam int OUT_W          = ((OUT_BITS + 7) / 8) * 8;
  localparam int FIELD_W        = skt_pkg::KEY_W;
  localparam int VAL_LSB        = 1;
  localparam int CNT_LSB        = VAL_LSB + skt_pkg::KEY_W;
  localparam int FULL_BIT       = CNT_LSB + CNT_W;
  localparam int PAD_LSB        = FULL_BIT + 1;
  localparam int PHASE_ITEMS    = 432;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_DIRECTED     = 25;

  localparam logic [skt_pkg::OPCODE_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [skt_pkg::OPCODE_W-1:0] OP_SPARE_B = 3'd7;

  typedef struct packed {
    logic [skt_pkg::STATUS_W-1:0] status;
    logic                         found;
    logic [skt_pkg::KEY_W-1:0]    value;
    logic [CNT_W-1:0]             count;
    logic                         full;
  } key_result_t;

  typedef struct packed {
    logic [skt_pkg::OPCODE_W-1:0] op;
    logic [skt_pkg::KEY_W-1:0]    key;
    logic                         typed;
    key_result_t                  res;
  } stim_row_t;

  logic                         clk      = 1'b0;
  logic                         rst      = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [skt_pkg::KEY_W-1:0]    s_tdata  = '0;
  logic [skt_pkg::OPCODE_W-1:0] s_tuser  = skt_pkg::OP_CLEAR;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [OUT_W-1:0]             m_tdata;
  logic [skt_pkg::STATUS_W-1:0] m_tuser;

  logic [skt_pkg::KEY_W-1:0] held_keys [KEY_SLOTS];
  int                        held_count;
  int                        read_ptr;

  key_result_t pending_results [$];
  int          err_count;
  int          items_sent;
  int          results_seen;
  int          full_refusals;
  int          dup_refusals;
  int          past_end_reads;
  int          idle_cycles;
  int          send_idle_pct;
  int          recv_stall_pct;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{skt_pkg::OP_READ, 32'h0000_0000, 1'b1,
      '{skt_pkg::ST_PAST_END, 1'b0, 32'h0, 7'd0, 1'b0}},
    '{skt_pkg::OP_DELETE, 32'h0000_0005, 1'b1,
      '{skt_pkg::ST_NOT_FOUND, 1'b0, 32'h0, 7'd0, 1'b0}},
    '{skt_pkg::OP_SEARCH, 32'h0000_0000, 1'b1,
      '{skt_pkg::ST_DONE, 1'b0, 32'h0, 7'd0, 1'b0}},
    '{skt_pkg::OP_INSERT, 32'h0000_0000, 1'b1,
      '{skt_pkg::ST_DONE, 1'b0, 32'h0, 7'd1, 1'b0}},
    '{skt_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1,
      '{skt_pkg::ST_DONE, 1'b0, 32'h0, 7'd2, 1'b0}},
    '{skt_pkg::OP_INSERT, 32'h0000_0000, 1'b1,
      '{skt_pkg::ST_DUPLICATE, 1'b0, 32'h0, 7'd2, 1'b0}},
    '{skt_pkg::OP_INSERT, 32'h0000_0064, 1'b0, '0},
    '{skt_pkg::OP_SEARCH, 32'hFFFF_FFFF, 1'b1,
      '{skt_pkg::ST_DONE, 1'b1, 32'h0, 7'd3, 1'b0}},
    '{skt_pkg::OP_SEARCH, 32'h0000_0065, 1'b0, '0},
    '{skt_pkg::OP_REWIND, 32'h5A5A_5A5A, 1'b0, '0},
    '{skt_pkg::OP_READ, 32'h0000_0000, 1'b1,
      '{skt_pkg::ST_DONE, 1'b0, 32'h0, 7'd3, 1'b0}},
    '{skt_pkg::OP_READ, 32'hFFFF_FFFF, 1'b0, '0},
    '{skt_pkg::OP_READ, 32'h0000_0000, 1'b1,
      '{skt_pkg::ST_DONE, 1'b0, 32'hFFFF_FFFF, 7'd3, 1'b0}},
    '{skt_pkg::OP_READ, 32'h0000_0000, 1'b1,
      '{skt_pkg::ST_PAST_END, 1'b0, 32'h0, 7'd3, 1'b0}},
    '{skt_pkg::OP_DELETE, 32'h0000_0064, 1'b1,
      '{skt_pkg::ST_DONE, 1'b0, 32'h0, 7'd2, 1'b0}},
    '{skt_pkg::OP_READ, 32'h0000_0000, 1'b0, '0},
    '{skt_pkg::OP_DELETE, 32'h0000_0064, 1'b1,
      '{skt_pkg::ST_NOT_FOUND, 1'b0, 32'h0, 7'd2, 1'b0}},
    '{OP_SPARE_A, 32'hFFFF_FFFF, 1'b1,
      '{skt_pkg::ST_DONE, 1'b0, 32'h0, 7'd2, 1'b0}},
    '{OP_SPARE_B, 32'h0000_0000, 1'b1,
      '{skt_pkg::ST_DONE, 1'b0, 32'h0, 7'd2, 1'b0}},
    '{skt_pkg::OP_INSERT, 32'h8000_0000, 1'b0, '0},
    '{skt_pkg::OP_READ, 32'h0000_0000, 1'b0, '0},
    '{skt_pkg::OP_CLEAR, 32'hFFFF_FFFF, 1'b1,
      '{skt_pkg::ST_DONE, 1'b0, 32'h0, 7'd0, 1'b0}},
    '{skt_pkg::OP_SEARCH, 32'hFFFF_FFFF, 1'b1,
      '{skt_pkg::ST_DONE, 1'b0, 32'h0, 7'd0, 1'b0}},
    '{skt_pkg::OP_READ, 32'h0000_0000, 1'b1,
      '{skt_pkg::ST_PAST_END, 1'b0, 32'h0, 7'd0, 1'b0}},
    '{skt_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b0, '0}
  };

  sorted_key_table #(
    .DEPTH    (KEY_SLOTS),
    .KEY_BITS (skt_pkg::KEY_BITS_DEFAULT)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic predict_table_op(input logic [skt_pkg::OPCODE_W-1:0] op,
                                  input logic [skt_pkg::KEY_W-1:0] key,
                                  output key_result_t r);
    int pos;
    r = '0;
    r.status = skt_pkg::ST_DONE;
    pos = 0;
    while (pos < held_count && held_keys[pos] < key) pos++;
    case (op)
      skt_pkg::OP_CLEAR: begin
        held_count = 0;
        read_ptr = 0;
      end
      skt_pkg::OP_INSERT: begin
        if (held_count >= KEY_SLOTS) begin
          r.status = skt_pkg::ST_FULL;
        end else if (pos < held_count && held_keys[pos] == key) begin
          r.status = skt_pkg::ST_DUPLICATE;
        end else begin
          for (int i = held_count; i > pos; i--) held_keys[i] = held_keys[i-1];
          held_keys[pos] = key;
          held_count++;
        end
      end
      skt_pkg::OP_DELETE: begin
        if (pos < held_count && held_keys[pos] == key) begin
          for (int i = pos; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
          held_count--;
        end else begin
          r.status = skt_pkg::ST_NOT_FOUND;
        end
      end
      skt_pkg::OP_SEARCH: begin
        r.found = (pos < held_count && held_keys[pos] == key);
      end
      skt_pkg::OP_REWIND: begin
        read_ptr = 0;
      end
      skt_pkg::OP_READ: begin
        if (read_ptr < held_count) begin
          r.value = held_keys[read_ptr];
          read_ptr++;
        end else begin
          r.status = skt_pkg::ST_PAST_END;
        end
      end
      default: begin
      end
    endcase
    r.count = held_count[CNT_W-1:0];
    r.full  = (held_count == KEY_SLOTS);
  endtask

  // hold valid until the transaction is taken, then predict and queue
  task automatic send_item(input logic [skt_pkg::OPCODE_W-1:0] op,
                           input logic [skt_pkg::KEY_W-1:0] key,
                           input logic typed = 1'b0, input key_result_t typed_res = '0);
    key_result_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= key;
    do @(posedge clk); while (!s_tready);
    predict_table_op(op, key, r);
    if (r.status == skt_pkg::ST_FULL) full_refusals++;
    if (r.status == skt_pkg::ST_DUPLICATE) dup_refusals++;
    if (r.status == skt_pkg::ST_PAST_END) past_end_reads++;
    pending_results.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  function automatic logic [skt_pkg::KEY_W-1:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 55) return $urandom_range(31);
    if (sel < 70) return 32'hFFFF_FFFF - $urandom_range(15);
    if (sel < 85 && held_count > 0) return held_keys[$urandom_range(held_count - 1)];
    return $urandom;
  endfunction

  task automatic run_sequence();
    int kind;
    int n;
    logic [skt_pkg::OPCODE_W-1:0] op;
    kind = $urandom_range(99);
    if (kind < 50) begin
      repeat ($urandom_range(24, 8)) begin
        n = $urandom_range(99);
        if (n < 2)       op = skt_pkg::OP_CLEAR;
        else if (n < 42) op = skt_pkg::OP_INSERT;
        else if (n < 62) op = skt_pkg::OP_DELETE;
        else if (n < 80) op = skt_pkg::OP_SEARCH;
        else if (n < 85) op = skt_pkg::OP_REWIND;
        else             op = skt_pkg::OP_READ;
        send_item(op, pick_key());
      end
    end else if (kind < 56) begin
      send_item(skt_pkg::OP_CLEAR, $urandom);
      while (held_count < KEY_SLOTS)
        send_item(skt_pkg::OP_INSERT, ($urandom_range(3) == 0) ? pick_key() : $urandom);
      send_item(skt_pkg::OP_INSERT, $urandom);
      send_item(skt_pkg::OP_INSERT, held_keys[$urandom_range(KEY_SLOTS - 1)]);
      send_item(skt_pkg::OP_SEARCH, held_keys[$urandom_range(KEY_SLOTS - 1)]);
      repeat ($urandom_range(6, 1))
        send_item(skt_pkg::OP_DELETE, held_keys[$urandom_range(held_count - 1)]);
    end else if (kind < 72) begin
      send_item(skt_pkg::OP_REWIND, $urandom);
      repeat (held_count + $urandom_range(2)) send_item(skt_pkg::OP_READ, $urandom);
    end else if (kind < 86) begin
      repeat ($urandom_range(12, 4)) send_item(skt_pkg::OP_DELETE, pick_key());
    end else begin
      repeat ($urandom_range(6, 1)) begin
        n = $urandom_range(7);
        send_item(n[skt_pkg::OPCODE_W-1:0], $urandom);
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, actual %h", $time, name, want, got);
      err_count++;
    end
  endtask

  task automatic check_result();
    key_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, status %h data %h", $time, m_tuser, m_tdata);
      err_count++;
    end else begin
      want = pending_results.pop_front();
      compare_field("status", FIELD_W'(want.status), FIELD_W'(m_tuser));
      compare_field("found", FIELD_W'(want.found), FIELD_W'(m_tdata[0]));
      compare_field("read_value", want.value, m_tdata[CNT_LSB-1:VAL_LSB]);
      compare_field("entry_count", FIELD_W'(want.count),
                    FIELD_W'(m_tdata[FULL_BIT-1:CNT_LSB]));
      compare_field("table_full", FIELD_W'(want.full), FIELD_W'(m_tdata[FULL_BIT]));
      compare_field("padding", '0, FIELD_W'(m_tdata[OUT_W-1:PAD_LSB]));
      results_seen++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result();
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int phase_start;
    held_count     = 0;
    read_ptr       = 0;
    err_count      = 0;
    items_sent     = 0;
    results_seen   = 0;
    full_refusals  = 0;
    dup_refusals   = 0;
    past_end_reads = 0;
    idle_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].key, directed_rows[i].typed,
                directed_rows[i].res);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) run_sequence();
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transactions, checked %0d results.", items_sent, results_seen);
    $display("Refused full: %0d, refused duplicate: %0d, reads past end: %0d.",
             full_refusals, dup_refusals, past_end_reads);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/skt_pkg.sv
rtl/skt_cell.sv
rtl/sorted_key_table.sv
tb/sv/sorted_key_table_tb.sv
